// ===== rtl/gwsp_pkg.sv =====
package gwsp_pkg;

  // Default store geometry.
  localparam int DEF_MAX_ROWS = 32;
  localparam int DEF_MAX_COLS = 32;

  // Fixed field widths of the item and configuration channels.
  localparam int KIND_W  = 2;
  localparam int COORD_W = 5;
  localparam int TILE_W  = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 6;
  localparam int COST_W  = 12;
  localparam int COUNT_W = 11;

  // Saturation limits of the reported values.
  localparam int COST_MAX  = 4095;
  localparam int COUNT_MAX = 2047;

  // Item kinds.
  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD  = 2'd0,
    KIND_RUN   = 2'd1,
    KIND_QUERY = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  // Tile codes.
  localparam logic [TILE_W-1:0] TILE_FLOOR  = 3'd0;
  localparam logic [TILE_W-1:0] TILE_WALL   = 3'd1;
  localparam logic [TILE_W-1:0] TILE_ROUGH  = 3'd2;
  localparam logic [TILE_W-1:0] TILE_TARGET = 3'd4;
  localparam logic [TILE_W-1:0] TILE_EXIT   = 3'd5;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_ROW = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_START_COL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_EXIT_GOAL = 3'd4;

endpackage

// ===== rtl/grid_weighted_shortest_path_unit.sv =====
// Grid shortest-path unit. Load items write one tile code each.
// A run item first clears the search store, all 2**(RW+CW) entries where RW and CW are
// the address bits of MAX_ROWS and MAX_COLS (1024 entries at 32 by 32), the same
// pass that runs once after reset before the first item is taken. It then settles
// cells one at a time: each settle scans every cell in use through the search
// store's read port, decides, writes the settled entry and tests for a goal, and
// visits the four neighbors. A run ends when a scan finds no cell left to settle,
// or at once when the start cell lies outside the grid, and then writes its result.
// Query items take one store read and then the result register.
module grid_weighted_shortest_path_unit #(
  parameter int MAX_ROWS = gwsp_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = gwsp_pkg::DEF_MAX_COLS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [gwsp_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [gwsp_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [gwsp_pkg::KIND_W-1:0]       kind_i,
  input  logic [gwsp_pkg::COORD_W-1:0]      cell_row_i,
  input  logic [gwsp_pkg::COORD_W-1:0]      cell_col_i,
  input  logic [gwsp_pkg::TILE_W-1:0]       tile_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              found_o,
  output logic [gwsp_pkg::COORD_W-1:0]      goal_row_o,
  output logic [gwsp_pkg::COORD_W-1:0]      goal_col_o,
  output logic [gwsp_pkg::COST_W-1:0]       path_cost_o,
  output logic [gwsp_pkg::COUNT_W-1:0]      settled_count_o,
  output logic                              reachable_o,
  output logic [gwsp_pkg::COST_W-1:0]       cell_distance_o,
  output logic                              prev_valid_o,
  output logic [gwsp_pkg::COORD_W-1:0]      prev_row_o,
  output logic [gwsp_pkg::COORD_W-1:0]      prev_col_o
);

  import gwsp_pkg::*;

  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int AW    = RW + CW;
  localparam int DEPTH = 1 << AW;
  localparam int RCW   = $clog2(MAX_ROWS + 1);
  localparam int CCW   = $clog2(MAX_COLS + 1);
  localparam int DW    = $clog2(3 * MAX_ROWS * MAX_COLS) + 1;
  localparam int SCW   = $clog2(MAX_ROWS * MAX_COLS + 1);

  // Move directions and the predecessor codes stored for them.
  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_DOWN  = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
  localparam logic [1:0] DIR_RIGHT = 2'd3;
  localparam logic [2:0] PRED_UP    = 3'd1;
  localparam logic [2:0] PRED_DOWN  = 3'd2;
  localparam logic [2:0] PRED_LEFT  = 3'd3;
  localparam logic [2:0] PRED_RIGHT = 3'd4;

  typedef struct packed {
    logic          reached;
    logic          settled;
    logic [2:0]    pred;
    logic [DW-1:0] distance;
  } entry_t;

  typedef enum logic [11:0] {
    ST_IDLE      = 12'b000000000001,
    ST_CLEAR     = 12'b000000000010,
    ST_INIT      = 12'b000000000100,
    ST_SCAN_INIT = 12'b000000001000,
    ST_SCAN      = 12'b000000010000,
    ST_SCAN_LAST = 12'b000000100000,
    ST_DECIDE    = 12'b000001000000,
    ST_SETTLE    = 12'b000010000000,
    ST_GOAL      = 12'b000100000000,
    ST_NB_ISSUE  = 12'b001000000000,
    ST_NB_EVAL   = 12'b010000000000,
    ST_FINISH    = 12'b100000000000
  } state_e;

  // A query shares the idle state's read and is finished in the cycle after it.
  state_e state_q, state_d;
  logic   query_q, query_d;
  logic   clr_run_q, clr_run_d;

  // Configuration registers.
  logic [CFG_DATA_W-1:0] row_count_q, col_count_q;
  logic [COORD_W-1:0]    start_row_q, start_col_q;
  logic                  exit_goal_q;

  // Search registers.
  logic [RCW-1:0] rows_q, rows_d;
  logic [CCW-1:0] cols_q, cols_d;
  logic [AW-1:0]  clr_q, clr_d;
  logic [RW-1:0]  sr_q, sr_d, pend_r_q, pend_r_d, best_r_q, best_r_d, goal_r_q, goal_r_d;
  logic [CW-1:0]  sc_q, sc_d, pend_c_q, pend_c_d, best_c_q, best_c_d, goal_c_q, goal_c_d;
  logic           pend_q, pend_d, best_valid_q, best_valid_d, goal_valid_q, goal_valid_d;
  logic [DW-1:0]  best_dist_q, best_dist_d, goal_dist_q, goal_dist_d;
  logic [2:0]     best_pred_q, best_pred_d;
  logic [1:0]     dir_q, dir_d;
  logic [RW-1:0]  nb_r_q, nb_r_d;
  logic [CW-1:0]  nb_c_q, nb_c_d;
  logic [SCW-1:0] settled_q, settled_d;

  // Query registers.
  logic [COORD_W-1:0] q_row_q, q_row_d, q_col_q, q_col_d;
  logic               q_in_q, q_in_d;

  // Result register.
  logic                out_valid_q, out_valid_d;
  logic                found_q, found_d, reach_q, reach_d, pv_q, pv_d;
  logic [COORD_W-1:0]  grow_q, grow_d, gcol_q, gcol_d, prow_q, prow_d, pcol_q, pcol_d;
  logic [COST_W-1:0]   cost_q, cost_d, cdist_q, cdist_d;
  logic [COUNT_W-1:0]  cnt_q, cnt_d;

  // Store ports.
  logic             st_we, tl_we;
  logic [AW-1:0]    st_waddr, tl_waddr, raddr;
  entry_t           st_wdata, st_rdata;
  logic [TILE_W-1:0] tl_rdata;

  logic in_acc, load_ok, query_ok;
  logic row_last, col_last, cand, nb_ok, upd, is_goal;
  logic [RW-1:0] nb_r;
  logic [CW-1:0] nb_c;
  logic [DW-1:0] nd;
  logic [1:0]    wt;
  int            rc, cc;

  gwsp_ram #(.WIDTH(TILE_W), .DEPTH(DEPTH)) u_tile_ram (
    .clk_i   (clk_i),
    .we_i    (tl_we),
    .waddr_i (tl_waddr),
    .wdata_i (tile_i),
    .raddr_i (raddr),
    .rdata_o (tl_rdata)
  );

  gwsp_ram #(.WIDTH($bits(entry_t)), .DEPTH(DEPTH)) u_search_ram (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .raddr_i (raddr),
    .rdata_o (st_rdata)
  );

  // Configuration writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= CFG_DATA_W'(32);
      col_count_q <= CFG_DATA_W'(32);
      start_row_q <= '0;
      start_col_q <= '0;
      exit_goal_q <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_ROW_COUNT: row_count_q <= cfg_data_i;
        REG_COL_COUNT: col_count_q <= cfg_data_i;
        REG_START_ROW: start_row_q <= cfg_data_i[COORD_W-1:0];
        REG_START_COL: start_col_q <= cfg_data_i[COORD_W-1:0];
        REG_EXIT_GOAL: exit_goal_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Input handshake: a run or query item also needs a free result register.
  assign in_ready_o = (state_q == ST_IDLE) && !query_q &&
                      (kind_i == KIND_LOAD || kind_i == KIND_NONE ||
                       !out_valid_q || out_ready_i);
  assign in_acc   = in_valid_i && in_ready_o;
  assign load_ok  = (int'(cell_row_i) < MAX_ROWS) && (int'(cell_col_i) < MAX_COLS);
  assign query_ok = load_ok;

  // Tile loads.
  assign tl_we    = in_acc && (kind_i == KIND_LOAD) && load_ok;
  assign tl_waddr = {RW'(cell_row_i), CW'(cell_col_i)};

  // Scan position and candidate test on the entry read in the previous cycle.
  assign row_last = (RCW'(sr_q) + RCW'(1)) == rows_q;
  assign col_last = (CCW'(sc_q) + CCW'(1)) == cols_q;
  assign cand = pend_q && st_rdata.reached && !st_rdata.settled &&
                (!best_valid_q || st_rdata.distance < best_dist_q);

  // Neighbor of the settled cell in the current direction.
  always_comb begin
    nb_ok = 1'b0;
    nb_r  = best_r_q;
    nb_c  = best_c_q;
    case (dir_q)
      DIR_UP: begin
        nb_ok = best_r_q != '0;
        nb_r  = best_r_q - RW'(1);
      end
      DIR_DOWN: begin
        nb_ok = (RCW'(best_r_q) + RCW'(1)) < rows_q;
        nb_r  = best_r_q + RW'(1);
      end
      DIR_LEFT: begin
        nb_ok = best_c_q != '0;
        nb_c  = best_c_q - CW'(1);
      end
      default: begin
        nb_ok = (CCW'(best_c_q) + CCW'(1)) < cols_q;
        nb_c  = best_c_q + CW'(1);
      end
    endcase
  end

  // Step cost of entering the neighbor and the relaxation test.
  always_comb begin
    case (tl_rdata)
      TILE_FLOOR: wt = 2'd1;
      TILE_ROUGH: wt = 2'd3;
      default:    wt = 2'd2;
    endcase
  end
  assign nd  = best_dist_q + DW'(wt);
  assign upd = (tl_rdata != TILE_WALL) &&
               (!st_rdata.reached || nd < st_rdata.distance);
  assign is_goal = (tl_rdata == TILE_TARGET) || (tl_rdata == TILE_EXIT && exit_goal_q);

  // Shared read address of both stores.
  always_comb begin
    raddr = {RW'(cell_row_i), CW'(cell_col_i)};
    if (state_q == ST_SCAN) begin
      raddr = {sr_q, sc_q};
    end else if (state_q == ST_SETTLE) begin
      raddr = {best_r_q, best_c_q};
    end else if (state_q == ST_NB_ISSUE) begin
      raddr = {nb_r, nb_c};
    end
  end

  // Effective grid size from the count registers.
  always_comb begin
    rc = int'(row_count_q);
    cc = int'(col_count_q);
    if (rc == 0) rc = 1;
    if (rc > MAX_ROWS) rc = MAX_ROWS;
    if (cc == 0) cc = 1;
    if (cc > MAX_COLS) cc = MAX_COLS;
  end

  // Sequencer.
  always_comb begin
    state_d      = state_q;
    query_d      = 1'b0;
    clr_run_d    = clr_run_q;
    rows_d       = rows_q;
    cols_d       = cols_q;
    clr_d        = clr_q;
    sr_d         = sr_q;
    sc_d         = sc_q;
    pend_d       = 1'b0;
    pend_r_d     = sr_q;
    pend_c_d     = sc_q;
    best_valid_d = best_valid_q;
    best_r_d     = best_r_q;
    best_c_d     = best_c_q;
    best_dist_d  = best_dist_q;
    best_pred_d  = best_pred_q;
    goal_valid_d = goal_valid_q;
    goal_r_d     = goal_r_q;
    goal_c_d     = goal_c_q;
    goal_dist_d  = goal_dist_q;
    dir_d        = dir_q;
    nb_r_d       = nb_r_q;
    nb_c_d       = nb_c_q;
    settled_d    = settled_q;
    q_row_d      = q_row_q;
    q_col_d      = q_col_q;
    q_in_d       = q_in_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    found_d      = found_q;
    grow_d       = grow_q;
    gcol_d       = gcol_q;
    cost_d       = cost_q;
    cnt_d        = cnt_q;
    reach_d      = reach_q;
    cdist_d      = cdist_q;
    pv_d         = pv_q;
    prow_d       = prow_q;
    pcol_d       = pcol_q;
    st_we        = 1'b0;
    st_waddr     = clr_q;
    st_wdata     = '0;

    // Scan compare runs in both scan states.
    if (cand) begin
      best_valid_d = 1'b1;
      best_r_d     = pend_r_q;
      best_c_d     = pend_c_q;
      best_dist_d  = st_rdata.distance;
      best_pred_d  = st_rdata.pred;
    end

    // Query result from the store read of the cycle before.
    if (query_q) begin
      out_valid_d = 1'b1;
      found_d = 1'b0;
      grow_d  = '0;
      gcol_d  = '0;
      cost_d  = '0;
      cnt_d   = '0;
      reach_d = 1'b0;
      cdist_d = '0;
      pv_d    = 1'b0;
      prow_d  = '0;
      pcol_d  = '0;
      if (q_in_q && st_rdata.reached) begin
        reach_d = 1'b1;
        cdist_d = (int'(st_rdata.distance) > COST_MAX) ? COST_W'(COST_MAX)
                                                       : COST_W'(st_rdata.distance);
        pv_d   = 1'b1;
        prow_d = q_row_q;
        pcol_d = q_col_q;
        case (st_rdata.pred)
          PRED_UP:    prow_d = q_row_q + COORD_W'(1);
          PRED_DOWN:  prow_d = q_row_q - COORD_W'(1);
          PRED_LEFT:  pcol_d = q_col_q + COORD_W'(1);
          PRED_RIGHT: pcol_d = q_col_q - COORD_W'(1);
          default: begin
            pv_d   = 1'b0;
            prow_d = '0;
            pcol_d = '0;
          end
        endcase
      end
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && kind_i == KIND_RUN) begin
          rows_d    = RCW'(rc);
          cols_d    = CCW'(cc);
          clr_d     = '0;
          clr_run_d = 1'b1;
          state_d   = ST_CLEAR;
        end else if (in_acc && kind_i == KIND_QUERY) begin
          query_d = 1'b1;
          q_row_d = cell_row_i;
          q_col_d = cell_col_i;
          q_in_d  = query_ok;
        end
      end
      ST_CLEAR: begin
        st_we    = 1'b1;
        st_waddr = clr_q;
        clr_d    = clr_q + AW'(1);
        if (&clr_q) begin
          state_d = clr_run_q ? ST_INIT : ST_IDLE;
        end
      end
      ST_INIT: begin
        goal_valid_d = 1'b0;
        goal_r_d     = '0;
        goal_c_d     = '0;
        goal_dist_d  = '0;
        settled_d    = '0;
        if (int'(start_row_q) >= int'(rows_q) || int'(start_col_q) >= int'(cols_q)) begin
          state_d = ST_FINISH;
        end else begin
          st_we            = 1'b1;
          st_waddr         = {RW'(start_row_q), CW'(start_col_q)};
          st_wdata.reached = 1'b1;
          state_d          = ST_SCAN_INIT;
        end
      end
      ST_SCAN_INIT: begin
        best_valid_d = 1'b0;
        sr_d         = '0;
        sc_d         = '0;
        state_d      = ST_SCAN;
      end
      ST_SCAN: begin
        pend_d = 1'b1;
        if (col_last) begin
          sc_d = '0;
          sr_d = sr_q + RW'(1);
          if (row_last) begin
            state_d = ST_SCAN_LAST;
          end
        end else begin
          sc_d = sc_q + CW'(1);
        end
      end
      ST_SCAN_LAST: begin
        state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        state_d = best_valid_q ? ST_SETTLE : ST_FINISH;
      end
      ST_SETTLE: begin
        st_we             = 1'b1;
        st_waddr          = {best_r_q, best_c_q};
        st_wdata.reached  = 1'b1;
        st_wdata.settled  = 1'b1;
        st_wdata.pred     = best_pred_q;
        st_wdata.distance = best_dist_q;
        settled_d         = settled_q + SCW'(1);
        state_d           = ST_GOAL;
      end
      ST_GOAL: begin
        if (is_goal) begin
          goal_valid_d = 1'b1;
          goal_r_d     = best_r_q;
          goal_c_d     = best_c_q;
          goal_dist_d  = best_dist_q;
        end
        dir_d   = DIR_UP;
        state_d = ST_NB_ISSUE;
      end
      ST_NB_ISSUE: begin
        nb_r_d = nb_r;
        nb_c_d = nb_c;
        if (nb_ok) begin
          state_d = ST_NB_EVAL;
        end else begin
          dir_d = dir_q + 2'd1;
          if (dir_q == DIR_RIGHT) begin
            state_d = ST_SCAN_INIT;
          end
        end
      end
      ST_NB_EVAL: begin
        if (upd) begin
          st_we             = 1'b1;
          st_waddr          = {nb_r_q, nb_c_q};
          st_wdata.reached  = 1'b1;
          st_wdata.settled  = st_rdata.settled;
          st_wdata.pred     = {1'b0, dir_q} + 3'd1;
          st_wdata.distance = nd;
        end
        dir_d   = dir_q + 2'd1;
        state_d = (dir_q == DIR_RIGHT) ? ST_SCAN_INIT : ST_NB_ISSUE;
      end
      ST_FINISH: begin
        out_valid_d = 1'b1;
        found_d     = goal_valid_q;
        grow_d      = goal_valid_q ? COORD_W'(goal_r_q) : '0;
        gcol_d      = goal_valid_q ? COORD_W'(goal_c_q) : '0;
        cost_d      = !goal_valid_q ? '0 :
                      (int'(goal_dist_q) > COST_MAX) ? COST_W'(COST_MAX)
                                                     : COST_W'(goal_dist_q);
        cnt_d       = (int'(settled_q) > COUNT_MAX) ? COUNT_W'(COUNT_MAX)
                                                    : COUNT_W'(settled_q);
        reach_d     = 1'b0;
        cdist_d     = '0;
        pv_d        = 1'b0;
        prow_d      = '0;
        pcol_d      = '0;
        state_d     = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control registers; the store is cleared once after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      query_q      <= 1'b0;
      clr_run_q    <= 1'b0;
      clr_q        <= '0;
      pend_q       <= 1'b0;
      best_valid_q <= 1'b0;
      goal_valid_q <= 1'b0;
      settled_q    <= '0;
      out_valid_q  <= 1'b0;
      rows_q       <= '0;
      cols_q       <= '0;
      sr_q         <= '0;
      sc_q         <= '0;
      dir_q        <= '0;
    end else begin
      state_q      <= state_d;
      query_q      <= query_d;
      clr_run_q    <= clr_run_d;
      clr_q        <= clr_d;
      pend_q       <= pend_d;
      best_valid_q <= best_valid_d;
      goal_valid_q <= goal_valid_d;
      settled_q    <= settled_d;
      out_valid_q  <= out_valid_d;
      rows_q       <= rows_d;
      cols_q       <= cols_d;
      sr_q         <= sr_d;
      sc_q         <= sc_d;
      dir_q        <= dir_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    pend_r_q    <= pend_r_d;
    pend_c_q    <= pend_c_d;
    best_r_q    <= best_r_d;
    best_c_q    <= best_c_d;
    best_dist_q <= best_dist_d;
    best_pred_q <= best_pred_d;
    goal_r_q    <= goal_r_d;
    goal_c_q    <= goal_c_d;
    goal_dist_q <= goal_dist_d;
    nb_r_q      <= nb_r_d;
    nb_c_q      <= nb_c_d;
    q_row_q     <= q_row_d;
    q_col_q     <= q_col_d;
    q_in_q      <= q_in_d;
    found_q     <= found_d;
    grow_q      <= grow_d;
    gcol_q      <= gcol_d;
    cost_q      <= cost_d;
    cnt_q       <= cnt_d;
    reach_q     <= reach_d;
    cdist_q     <= cdist_d;
    pv_q        <= pv_d;
    prow_q      <= prow_d;
    pcol_q      <= pcol_d;
  end

  assign out_valid_o     = out_valid_q;
  assign found_o         = found_q;
  assign goal_row_o      = grow_q;
  assign goal_col_o      = gcol_q;
  assign path_cost_o     = cost_q;
  assign settled_count_o = cnt_q;
  assign reachable_o     = reach_q;
  assign cell_distance_o = cdist_q;
  assign prev_valid_o    = pv_q;
  assign prev_row_o      = prow_q;
  assign prev_col_o      = pcol_q;

endmodule

// ===== rtl/gwsp_ram.sv =====
module gwsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== verif/tb_top.sv =====
module tb_top;
  import gwsp_pkg::*;

  // One result item as seen on the output port.
  typedef struct {
    int found;
    int goal_row;
    int goal_col;
    int path_cost;
    int settled_count;
    int reachable;
    int cell_distance;
    int prev_valid;
    int prev_row;
    int prev_col;
  } path_result_t;

  // Shadow of the grid engine plus the queue of results it still owes.
  class path_scoreboard;
    logic [TILE_W-1:0] tile_mem[DEF_MAX_ROWS*DEF_MAX_COLS];
    int distance[DEF_MAX_ROWS*DEF_MAX_COLS];
    bit reached[DEF_MAX_ROWS*DEF_MAX_COLS];
    int came_from[DEF_MAX_ROWS*DEF_MAX_COLS];
    bit closed[DEF_MAX_ROWS*DEF_MAX_COLS];
    int drow[4] = '{-1, 1, 0, 0};
    int dcol[4] = '{0, 0, -1, 1};
    int rows_reg;
    int cols_reg;
    int start_r;
    int start_c;
    bit exit_goal;
    bit goal_ok;
    int goal_r;
    int goal_c;
    int settled_n;
    path_result_t owed_q[$];
    int errors;

    function new();
      foreach (tile_mem[i]) tile_mem[i] = TILE_FLOOR;
      clear_search();
      rows_reg = 32;
      cols_reg = 32;
      start_r = 0;
      start_c = 0;
      exit_goal = 0;
      errors = 0;
    endfunction

    function void clear_search();
      foreach (distance[i]) begin
        distance[i] = 0;
        reached[i] = 0;
        came_from[i] = 0;
        closed[i] = 0;
      end
      goal_ok = 0;
      goal_r = 0;
      goal_c = 0;
      settled_n = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_ROW_COUNT: rows_reg = int'(data);
        REG_COL_COUNT: cols_reg = int'(data);
        REG_START_ROW: start_r = int'(data[COORD_W-1:0]);
        REG_START_COL: start_c = int'(data[COORD_W-1:0]);
        REG_EXIT_GOAL: exit_goal = data[0];
        default: ;
      endcase
    endfunction

    // Settle cells in (distance, row, col) order from the start cell.
    function void search();
      int rows, cols, bi, br, bc, nr, nc, ni, nd, w;
      bit have;
      logic [TILE_W-1:0] t;
      clear_search();
      rows = (rows_reg == 0) ? 1 : (rows_reg > DEF_MAX_ROWS) ? DEF_MAX_ROWS : rows_reg;
      cols = (cols_reg == 0) ? 1 : (cols_reg > DEF_MAX_COLS) ? DEF_MAX_COLS : cols_reg;
      if (start_r >= rows || start_c >= cols) return;
      reached[start_r*DEF_MAX_COLS + start_c] = 1;
      while (1) begin
        have = 0;
        bi = 0;
        br = 0;
        bc = 0;
        for (int r = 0; r < rows; r++)
          for (int c = 0; c < cols; c++)
            if (reached[r*DEF_MAX_COLS + c] && !closed[r*DEF_MAX_COLS + c] &&
                (!have || distance[r*DEF_MAX_COLS + c] < distance[bi])) begin
              have = 1;
              bi = r*DEF_MAX_COLS + c;
              br = r;
              bc = c;
            end
        if (!have) break;
        closed[bi] = 1;
        settled_n++;
        if (tile_mem[bi] == TILE_TARGET || (tile_mem[bi] == TILE_EXIT && exit_goal)) begin
          goal_ok = 1;
          goal_r = br;
          goal_c = bc;
        end
        for (int d = 0; d < 4; d++) begin
          nr = br + drow[d];
          nc = bc + dcol[d];
          if (nr < 0 || nc < 0 || nr >= rows || nc >= cols) continue;
          ni = nr*DEF_MAX_COLS + nc;
          t = tile_mem[ni];
          if (t == TILE_WALL) continue;
          w = (t == TILE_FLOOR) ? 1 : (t == TILE_ROUGH) ? 3 : 2;
          nd = distance[bi] + w;
          if (!reached[ni] || nd < distance[ni]) begin
            reached[ni] = 1;
            distance[ni] = nd;
            came_from[ni] = d + 1;
          end
        end
      end
    endfunction

    // Update the shadow for an accepted input item and queue any result it causes.
    function void note_input(kind_e k, int r, int c, int t);
      path_result_t e;
      int i;
      e = '{default: 0};
      case (k)
        KIND_LOAD: tile_mem[r*DEF_MAX_COLS + c] = TILE_W'(t);
        KIND_RUN: begin
          search();
          if (goal_ok) begin
            e.found = 1;
            e.goal_row = goal_r;
            e.goal_col = goal_c;
            e.path_cost = (distance[goal_r*DEF_MAX_COLS + goal_c] > COST_MAX) ? COST_MAX :
                          distance[goal_r*DEF_MAX_COLS + goal_c];
          end
          e.settled_count = (settled_n > COUNT_MAX) ? COUNT_MAX : settled_n;
          owed_q = {owed_q, e};
        end
        KIND_QUERY: begin
          i = r*DEF_MAX_COLS + c;
          if (reached[i]) begin
            e.reachable = 1;
            e.cell_distance = (distance[i] > COST_MAX) ? COST_MAX : distance[i];
            if (came_from[i] != 0) begin
              e.prev_valid = 1;
              e.prev_row = (r - drow[came_from[i]-1]) & 31;
              e.prev_col = (c - dcol[came_from[i]-1]) & 31;
            end
          end
          owed_q = {owed_q, e};
        end
        default: ;
      endcase
    endfunction

    function void compare(string name, int want, int got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(path_result_t got);
      path_result_t want;
      if (owed_q.size() == 0) begin
        $error("result item arrived with none expected");
        errors++;
        return;
      end
      want = owed_q.pop_front();
      compare("found", want.found, got.found);
      compare("goal_row", want.goal_row, got.goal_row);
      compare("goal_col", want.goal_col, got.goal_col);
      compare("path_cost", want.path_cost, got.path_cost);
      compare("settled_count", want.settled_count, got.settled_count);
      compare("reachable", want.reachable, got.reachable);
      compare("cell_distance", want.cell_distance, got.cell_distance);
      compare("prev_valid", want.prev_valid, got.prev_valid);
      compare("prev_row", want.prev_row, got.prev_row);
      compare("prev_col", want.prev_col, got.prev_col);
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic cfg_valid_i = 0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 0;
  logic in_ready_o;
  logic [KIND_W-1:0] kind_i = '0;
  logic [COORD_W-1:0] cell_row_i = '0;
  logic [COORD_W-1:0] cell_col_i = '0;
  logic [TILE_W-1:0] tile_i = '0;
  logic out_valid_o;
  logic out_ready_i = 0;
  logic found_o;
  logic [COORD_W-1:0] goal_row_o, goal_col_o, prev_row_o, prev_col_o;
  logic [COST_W-1:0] path_cost_o, cell_distance_o;
  logic [COUNT_W-1:0] settled_count_o;
  logic reachable_o, prev_valid_o;

  path_scoreboard sb = new();
  bit loaded[DEF_MAX_ROWS*DEF_MAX_COLS];
  bit no_idle = 0;
  bit hold_req = 0;
  int items_sent = 0;

  always #5 clk_i = ~clk_i;

  grid_weighted_shortest_path_unit u_dut (.*);

  // Mostly short gaps, now and then a long one; none at all in calm stretches.
  function automatic int pick_gap();
    int x;
    x = $urandom_range(0, 99);
    if (no_idle || x < 60) return 0;
    if (x < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_item(kind_e k, int r, int c, int t);
    int g;
    g = pick_gap();
    if (g > 0) begin
      in_valid_i <= 0;
      repeat (g) @(posedge clk_i);
    end
    in_valid_i <= 1;
    kind_i <= k;
    cell_row_i <= COORD_W'(r);
    cell_col_i <= COORD_W'(c);
    tile_i <= TILE_W'(t);
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_input(k, r, c, t);
    if (k == KIND_LOAD) loaded[r*DEF_MAX_COLS + c] = 1;
    items_sent++;
  endtask

  // Wait until every owed result is back and any trailing load has retired.
  task automatic wait_idle();
    in_valid_i <= 0;
    @(posedge clk_i);
    while (sb.owed_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int data);
    cfg_valid_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i <= CFG_DATA_W'(data);
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 0;
    sb.write_reg(idx, CFG_DATA_W'(data));
  endtask

  task automatic configure(int rows, int cols, int sr, int sc, int xg);
    write_reg(REG_ROW_COUNT, rows);
    write_reg(REG_COL_COUNT, cols);
    write_reg(REG_START_ROW, sr);
    write_reg(REG_START_COL, sc);
    write_reg(REG_EXIT_GOAL, xg);
  endtask

  // Give every cell of the grid in use a tile so that a run never reads a blank one.
  task automatic fill_grid();
    int rows, cols;
    rows = (sb.rows_reg == 0) ? 1 : (sb.rows_reg > DEF_MAX_ROWS) ? DEF_MAX_ROWS : sb.rows_reg;
    cols = (sb.cols_reg == 0) ? 1 : (sb.cols_reg > DEF_MAX_COLS) ? DEF_MAX_COLS : sb.cols_reg;
    for (int r = 0; r < rows; r++)
      for (int c = 0; c < cols; c++)
        if (!loaded[r*DEF_MAX_COLS + c]) send_item(KIND_LOAD, r, c, $urandom_range(0, 7));
  endtask

  // Receiver: random stalls, plus one long hold-off when the sender asks for it.
  initial begin
    int g;
    bit held;
    path_result_t got;
    held = 0;
    forever begin
      if (hold_req && !held) begin
        held = 1;
        out_ready_i <= 0;
        repeat (400) @(posedge clk_i);
      end
      g = pick_gap();
      if (g > 0) begin
        out_ready_i <= 0;
        repeat (g) @(posedge clk_i);
      end
      out_ready_i <= 1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      got.found = int'(found_o);
      got.goal_row = int'(goal_row_o);
      got.goal_col = int'(goal_col_o);
      got.path_cost = int'(path_cost_o);
      got.settled_count = int'(settled_count_o);
      got.reachable = int'(reachable_o);
      got.cell_distance = int'(cell_distance_o);
      got.prev_valid = int'(prev_valid_o);
      got.prev_row = int'(prev_row_o);
      got.prev_col = int'(prev_col_o);
      sb.check_result(got);
    end
  end

  // Stimulus: directed corner cases first, then random phases.
  initial begin
    int rows, cols, er, ec, n, x;
    bit big_done;
    big_done = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1;

    // Small grid holding every tile code, including the three unnamed ones.
    configure(3, 3, 1, 1, 0);
    send_item(KIND_LOAD, 0, 0, TILE_FLOOR);
    send_item(KIND_LOAD, 0, 1, TILE_WALL);
    send_item(KIND_LOAD, 0, 2, TILE_ROUGH);
    send_item(KIND_LOAD, 1, 0, 3);
    send_item(KIND_LOAD, 1, 1, TILE_FLOOR);
    send_item(KIND_LOAD, 1, 2, TILE_TARGET);
    send_item(KIND_LOAD, 2, 0, TILE_EXIT);
    send_item(KIND_LOAD, 2, 1, 6);
    send_item(KIND_LOAD, 2, 2, 7);
    send_item(KIND_RUN, 0, 0, 0);
    send_item(KIND_QUERY, 1, 2, 0);
    send_item(KIND_QUERY, 1, 1, 0);
    send_item(KIND_QUERY, 0, 1, 0);
    send_item(KIND_QUERY, 31, 31, 7);
    send_item(KIND_NONE, 31, 31, 7);
    wait_idle();
    // Exit tiles count as goals.
    write_reg(REG_EXIT_GOAL, 1);
    send_item(KIND_RUN, 0, 0, 0);
    send_item(KIND_QUERY, 2, 0, 0);
    wait_idle();
    // Zero grid size counts as one cell.
    configure(0, 0, 0, 0, 1);
    send_item(KIND_RUN, 0, 0, 0);
    wait_idle();
    // Start outside the grid settles nothing.
    configure(2, 3, 5, 0, 0);
    send_item(KIND_RUN, 0, 0, 0);
    send_item(KIND_QUERY, 0, 0, 0);
    wait_idle();
    // Wall at the start cell is still settled.
    configure(3, 3, 0, 1, 0);
    send_item(KIND_RUN, 0, 0, 0);
    send_item(KIND_QUERY, 0, 1, 0);
    wait_idle();
    // Oversized row count clamps to the store height.
    configure(63, 1, 0, 0, 1);
    fill_grid();
    send_item(KIND_RUN, 0, 0, 0);
    send_item(KIND_QUERY, 31, 0, 0);

    while (items_sent < 650) begin
      wait_idle();
      no_idle = ($urandom_range(0, 4) == 0);
      if (!big_done && items_sent > 300) begin
        // Full store with the start boxed in by walls: one settle, whole scan.
        // The scan still reads every cell, but only the start cell is ever settled.
        big_done = 1;
        configure(32, 32, 31, 31, $urandom_range(0, 1));
        send_item(KIND_LOAD, 30, 31, TILE_WALL);
        send_item(KIND_LOAD, 31, 30, TILE_WALL);
        send_item(KIND_LOAD, 31, 31, $urandom_range(0, 7));
        send_item(KIND_RUN, 0, 0, 0);
        send_item(KIND_QUERY, 31, 31, 0);
        send_item(KIND_QUERY, 0, 0, 0);
        continue;
      end
      x = $urandom_range(0, 99);
      if (x < 85) begin
        rows = $urandom_range(1, 6);
        cols = $urandom_range(1, 6);
      end else if (x < 92) begin
        rows = (x & 1) ? 63 : 32;
        cols = $urandom_range(0, 2);
      end else begin
        rows = $urandom_range(0, 2);
        cols = (x & 1) ? 63 : 32;
      end
      er = (rows == 0) ? 1 : (rows > 32) ? 32 : rows;
      ec = (cols == 0) ? 1 : (cols > 32) ? 32 : cols;
      if ($urandom_range(0, 9) == 0)
        configure(rows, cols, $urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 1));
      else
        configure(rows, cols, $urandom_range(0, (er < 31) ? er : 31),
                  $urandom_range(0, ec - 1), $urandom_range(0, 1));
      fill_grid();
      // Random edits of the grid, with some noise mixed in.
      n = $urandom_range(3, 15);
      repeat (n) begin
        x = $urandom_range(0, 99);
        if (x < 60)
          send_item(KIND_LOAD, $urandom_range(0, er - 1), $urandom_range(0, ec - 1),
                    $urandom_range(0, 7));
        else if (x < 70)
          send_item(KIND_LOAD, $urandom_range(0, 31), $urandom_range(0, 31),
                    $urandom_range(0, 7));
        else if (x < 80)
          send_item(KIND_NONE, $urandom_range(0, 31), $urandom_range(0, 31),
                    $urandom_range(0, 7));
        else
          send_item(KIND_QUERY, $urandom_range(0, 31), $urandom_range(0, 31),
                    $urandom_range(0, 7));
      end
      send_item(KIND_RUN, $urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 7));
      // Trace the grid after the run; once, with the receiver held off.
      if (!hold_req && items_sent > 400) begin
        hold_req = 1;
        n = 30;
      end else begin
        n = $urandom_range(2, 10);
      end
      repeat (n) begin
        if ($urandom_range(0, 4) == 0)
          send_item(KIND_QUERY, $urandom_range(0, 31), $urandom_range(0, 31),
                    $urandom_range(0, 7));
        else
          send_item(KIND_QUERY, $urandom_range(0, er - 1), $urandom_range(0, ec - 1),
                    $urandom_range(0, 7));
      end
    end

    in_valid_i <= 0;
    @(posedge clk_i);
    while (sb.owed_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #20000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
